[sv/cca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, command codes and calendar helpers for the calendar clock.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam int YEAR_WIDTH_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// command codes (tuser)
	localparam logic [1:0] CMD_ADVANCE  = 2'd0;
	localparam logic [1:0] CMD_SET_TIME = 2'd1;
	localparam logic [1:0] CMD_SET_DATE = 2'd2;
	localparam logic [1:0] CMD_SET_BOTH = 2'd3;

	// reciprocal constants: q = (x * RECIP) >> SHIFT is exact over the input range
	localparam int          DIV60_A_SHIFT  = 28;              // 22-bit dividend
	localparam logic [22:0] DIV60_A_RECIP  = 23'd4473925;
	localparam int          DIV60_B_SHIFT  = 23;              // 17-bit dividend
	localparam logic [17:0] DIV60_B_RECIP  = 18'd139811;
	localparam int          DIV24_SHIFT    = 16;              // 11-bit dividend
	localparam logic [11:0] DIV24_RECIP    = 12'd2731;
	localparam int          DIV400_SHIFT   = 25;              // 16-bit dividend
	localparam logic [16:0] DIV400_RECIP   = 17'd83887;

	localparam logic [8:0]  RES_LAST       = 9'd399;

	// one classified command word, as queued between front and back
	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  sec_inc;
		logic [5:0]  min_inc;
		logic [4:0]  hour_inc;
		logic [5:0]  day_inc;
		logic [5:0]  new_second;
		logic [5:0]  new_minute;
		logic [4:0]  new_hour;
		logic [4:0]  new_day;
		logic [3:0]  new_month;
		logic [15:0] new_year;
		logic [8:0]  new_year_res;  // new_year mod 400
	} cca_item_t;

	// leap test from the year's low bits and its residue mod 400
	function automatic logic is_leap(input logic [1:0] year_lo, input logic [8:0] res);
		is_leap = (year_lo == 2'd0) && (res != 9'd100) && (res != 9'd200)
			&& (res != 9'd300);
	endfunction

	// 31/30 alternation switching at August, February by leap flag
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		if (month == 4'd2) begin
			month_len = leap ? 5'd29 : 5'd28;
		end else if (month <= 4'd7) begin
			month_len = month[0] ? 5'd31 : 5'd30;
		end else begin
			month_len = month[0] ? 5'd30 : 5'd31;
		end
	endfunction

endpackage
`default_nettype wire

[sv/cca_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_front
// Accepts command words and splits the elapsed count into second, minute,
// hour and day increments over three pipeline stages; reduces the load year.
// ----------------------------------------------------------------------------
module cca_front import cca_pkg::*; #(
	parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  in_cmd,
	input  wire logic [63:0] in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output cca_item_t        out_item
);

	localparam int LOAD_W = (YEAR_WIDTH < 16) ? YEAR_WIDTH : 16;
	localparam logic [15:0] LOAD_MASK = 16'((64'd1 << LOAD_W) - 64'd1);

	logic        v_s1, v_s2, v_s3;
	logic        adv1, adv2, adv3;
	cca_item_t   item_s1, item_s2, item_s3;
	logic [16:0] quo_s1;   // elapsed / 60
	logic [10:0] quo_s2;   // elapsed / 3600

	logic [21:0] elapsed;
	logic [44:0] prod_a;
	logic [16:0] quo_a;
	logic [15:0] year_ld;
	logic [32:0] prod_y;
	logic [7:0]  quo_y;
	logic [34:0] prod_b;
	logic [10:0] quo_b;
	logic [22:0] prod_c;
	logic [5:0]  quo_c;
	cca_item_t   item_in;
	cca_item_t   item_nx2, item_nx3;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: seconds and year residue
	always_comb begin
		elapsed = in_data[21:0];
		prod_a  = 45'(elapsed) * 45'(DIV60_A_RECIP);
		quo_a   = prod_a[DIV60_A_SHIFT +: 17];
		year_ld = in_data[63:48] & LOAD_MASK;
		prod_y  = 33'(year_ld) * 33'(DIV400_RECIP);
		quo_y   = prod_y[DIV400_SHIFT +: 8];

		item_in              = '0;
		item_in.cmd          = in_cmd;
		item_in.sec_inc      = 6'(elapsed - 22'(quo_a) * 22'd60);
		item_in.new_second   = in_data[27:22];
		item_in.new_minute   = in_data[33:28];
		item_in.new_hour     = in_data[38:34];
		item_in.new_day      = in_data[43:39];
		item_in.new_month    = in_data[47:44];
		item_in.new_year     = year_ld;
		item_in.new_year_res = 9'(year_ld - 16'(quo_y) * 16'd400);
	end

	// stage 2: minutes
	always_comb begin
		prod_b           = 35'(quo_s1) * 35'(DIV60_B_RECIP);
		quo_b            = prod_b[DIV60_B_SHIFT +: 11];
		item_nx2         = item_s1;
		item_nx2.min_inc = 6'(quo_s1 - 17'(quo_b) * 17'd60);
	end

	// stage 3: hours and days
	always_comb begin
		prod_c            = 23'(quo_s2) * 23'(DIV24_RECIP);
		quo_c             = prod_c[DIV24_SHIFT +: 6];
		item_nx3          = item_s2;
		item_nx3.hour_inc = 5'(quo_s2 - 11'(quo_c) * 11'd24);
		item_nx3.day_inc  = quo_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			item_s1 <= item_in;
			quo_s1  <= quo_a;
		end
		if (adv2 && v_s1) begin
			item_s2 <= item_nx2;
			quo_s2  <= quo_b;
		end
		if (adv3 && v_s2) begin
			item_s3 <= item_nx3;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

	// reciprocal division sanity
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (item_s1.sec_inc < 6'd60 && item_s1.new_year_res <= RES_LAST))
		else $error("front: second remainder or year residue out of range");
	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> item_s2.min_inc < 6'd60)
		else $error("front: minute remainder out of range");
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (item_s3.hour_inc < 5'd24 && item_s3.day_inc <= 6'd48))
		else $error("front: hour remainder or day count out of range");

endmodule
`default_nettype wire

[sv/cca_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_queue
// Short FIFO of classified command words between front and back.
// ----------------------------------------------------------------------------
module cca_queue import cca_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire cca_item_t push_item,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output cca_item_t      pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cca_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

[sv/cca_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_back
// Holds the date and time, applies one queued command word per cycle while
// the output word is not stalled, and presents the new state as the output word.
// ----------------------------------------------------------------------------
module cca_back import cca_pkg::*; #(
	parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire cca_item_t   q_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      out_data
);

	localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;

	logic                  out_valid_q;
	logic [5:0]            sec_q, min_q;
	logic [4:0]            hour_q, day_q;
	logic [3:0]            month_q;
	logic [YEAR_WIDTH-1:0] year_q;
	logic [8:0]            res_q;   // year_q mod 400

	logic                  pop;
	logic [6:0]            sec_sum, min_sum, day_sum;
	logic [5:0]            hour_sum;
	logic [1:0]            c_sec, c_min, c_hour;
	logic [5:0]            sec_adv, min_adv;
	logic [4:0]            hour_adv, mlen;
	logic [4:0]            month_inc;
	logic [4:0]            day_adv;
	logic [3:0]            month_adv;
	logic [YEAR_WIDTH-1:0] year_adv;
	logic [8:0]            res_adv;

	assign q_ready = !out_valid_q || out_ready;
	assign pop     = q_valid && q_ready;

	// advance: add the pre-split increments with small carries
	always_comb begin
		sec_sum = 7'(sec_q) + 7'(q_item.sec_inc);
		priority if (sec_sum >= 7'd120) begin
			sec_adv = 6'(sec_sum - 7'd120);
			c_sec   = 2'd2;
		end else if (sec_sum >= 7'd60) begin
			sec_adv = 6'(sec_sum - 7'd60);
			c_sec   = 2'd1;
		end else begin
			sec_adv = sec_sum[5:0];
			c_sec   = 2'd0;
		end

		min_sum = 7'(min_q) + 7'(q_item.min_inc) + 7'(c_sec);
		priority if (min_sum >= 7'd120) begin
			min_adv = 6'(min_sum - 7'd120);
			c_min   = 2'd2;
		end else if (min_sum >= 7'd60) begin
			min_adv = 6'(min_sum - 7'd60);
			c_min   = 2'd1;
		end else begin
			min_adv = min_sum[5:0];
			c_min   = 2'd0;
		end

		hour_sum = 6'(hour_q) + 6'(q_item.hour_inc) + 6'(c_min);
		priority if (hour_sum >= 6'd48) begin
			hour_adv = 5'(hour_sum - 6'd48);
			c_hour   = 2'd2;
		end else if (hour_sum >= 6'd24) begin
			hour_adv = 5'(hour_sum - 6'd24);
			c_hour   = 2'd1;
		end else begin
			hour_adv = hour_sum[4:0];
			c_hour   = 2'd0;
		end

		day_sum   = 7'(day_q) + 7'(q_item.day_inc) + 7'(c_hour);
		mlen      = month_len(month_q, is_leap(year_q[1:0], res_q));
		month_inc = 5'(month_q) + 5'd1;
		day_adv   = day_sum[4:0];
		month_adv = month_q;
		year_adv  = year_q;
		res_adv   = res_q;
		if (day_sum > 7'(mlen)) begin
			day_adv = 5'(day_sum - 7'(mlen));
			if (month_inc > 5'd12) begin
				month_adv = 4'(month_inc - 5'd12);
				if (year_q == YEAR_MAX) begin
					year_adv = '0;
					res_adv  = '0;
				end else begin
					year_adv = year_q + 1'b1;
					res_adv  = (res_q == RES_LAST) ? 9'd0 : res_q + 9'd1;
				end
			end else begin
				month_adv = month_inc[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= 5'd1;
			month_q     <= 4'd1;
			year_q      <= '0;
			res_q       <= '0;
		end else begin
			if (q_ready) out_valid_q <= q_valid;
			if (pop) begin
				unique case (q_item.cmd)
					CMD_ADVANCE: begin
						sec_q   <= sec_adv;
						min_q   <= min_adv;
						hour_q  <= hour_adv;
						day_q   <= day_adv;
						month_q <= month_adv;
						year_q  <= year_adv;
						res_q   <= res_adv;
					end
					CMD_SET_TIME: begin
						sec_q  <= q_item.new_second;
						min_q  <= q_item.new_minute;
						hour_q <= q_item.new_hour;
					end
					CMD_SET_DATE: begin
						day_q   <= q_item.new_day;
						month_q <= q_item.new_month;
						year_q  <= YEAR_WIDTH'(q_item.new_year);
						res_q   <= q_item.new_year_res;
					end
					CMD_SET_BOTH: begin
						sec_q   <= q_item.new_second;
						min_q   <= q_item.new_minute;
						hour_q  <= q_item.new_hour;
						day_q   <= q_item.new_day;
						month_q <= q_item.new_month;
						year_q  <= YEAR_WIDTH'(q_item.new_year);
						res_q   <= q_item.new_year_res;
					end
					default: begin
						sec_q <= sec_q;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'd0, 16'(year_q), month_q, day_q, hour_q, min_q, sec_q};

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= RES_LAST)
		else $error("back: year residue out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(sec_q) && $stable(year_q) && out_valid_q))
		else $error("back: state changed while the output word was stalled");
	a_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.cmd == CMD_ADVANCE && month_q >= 4'd1 && month_q <= 4'd12)
		|=> (month_q >= 4'd1 && month_q <= 4'd12))
		else $error("back: advance left a valid month out of range");

endmodule
`default_nettype wire

[sv/calendar_clock_advance.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_advance
// Gregorian date and time keeper driven by advance and load command words.
// ----------------------------------------------------------------------------
// Takes one command word per cycle unless back-pressure stalls it, and returns
// one date/time word per command, in order. The front splits the elapsed
// count into second, minute, hour and day increments in three multiply
// stages (reciprocal division by 60, 60 and 24) and reduces a load year mod
// 400; a four-word queue sits between it and the back, which updates the
// clock state once per word and registers it as the output word, so sustained
// throughput is one word per cycle while m_axis_tready stays high. Month lengths
// alternate 31/30 switching at August, February follows the 4/100/400 leap
// rule, and the year wraps at YEAR_WIDTH bits.
module calendar_clock_advance import cca_pkg::*; #(
	parameter int YEAR_WIDTH  = YEAR_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// elapsed_seconds, new_second, new_minute, new_hour, new_day, new_month, new_year
	input  wire logic [63:0] s_axis_tdata,
	// command
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year, zero pad
	output logic [47:0]      m_axis_tdata
);

	logic      fq_valid, fq_ready;
	cca_item_t fq_item;
	logic      qb_valid, qb_ready;
	cca_item_t qb_item;

	cca_front #(.YEAR_WIDTH(YEAR_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	cca_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	cca_back #(.YEAR_WIDTH(YEAR_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_item    (qb_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire
